### sv/tah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_pkg: shared types and constants for the threshold alarm
// Field widths, level and event codes, register indexes, saturating counters.
// ----------------------------------------------------------------------------
package tah_pkg;

    // Field widths
    localparam int KB_W      = 32;
    localparam int MB_W      = 22;
    localparam int RUN_W     = 16;
    localparam int TOT_W     = 32;
    localparam int WIN_W     = 23;
    localparam int MS_W      = 16;
    localparam int LVL_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 22;

    // MB to kB is a shift by ten
    localparam int KB_SHIFT = 10;

    // Alarm state codes
    localparam logic [LVL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARNING  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd2;

    // Event codes
    localparam logic [LVL_W-1:0] EV_WARNING  = 2'd0;
    localparam logic [LVL_W-1:0] EV_CRITICAL = 2'd1;
    localparam logic [LVL_W-1:0] EV_RECOVERY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_MB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_MB       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_MB      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_WINDOWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_WINDOWS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_WINDOWS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS      = 3'd7;

    // Register reset values
    localparam logic [MB_W-1:0]  RST_CRITICAL_MB  = 22'd256;
    localparam logic [MB_W-1:0]  RST_WARNING_MB   = 22'd512;
    localparam logic [MB_W-1:0]  RST_RECOVERY_MB  = 22'd768;
    localparam logic [RUN_W-1:0] RST_WINDOWS      = 16'd3;
    localparam logic [MS_W-1:0]  RST_INTERVAL_MS  = 16'd1000;

    // Counter ceilings
    localparam logic [RUN_W-1:0] RUN_MAX   = '1;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    // Divide by 1000 as (x >> 3) / 125; the 29-bit quotient by 125 is
    // (y * ceil(2^36 / 125)) >> 36, exact over the full 29-bit range.
    localparam int               SEC_PRE_SHIFT = 3;
    localparam int               SEC_SHIFT     = 36;
    localparam int               SEC_RECIP_W   = 30;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 30'd549755814;

    // Saturating run counter step
    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
        return (v == RUN_MAX) ? v : v + 16'd1;
    endfunction

    // Saturating total counter step
    function automatic logic [TOT_W-1:0] total_inc(input logic [TOT_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 32'd1;
    endfunction

endpackage

### sv/tah_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_in_if: sample channel
// One beat carries one memory sample and its valid flag.
// ----------------------------------------------------------------------------
interface tah_in_if;
    logic                        valid;
    logic                        ready;
    logic [tah_pkg::KB_W-1:0]    available_kb;
    logic                        sample_valid;

    modport source (output valid, output available_kb, output sample_valid, input ready);
    modport sink   (input valid, input available_kb, input sample_valid, output ready);
endinterface

### sv/tah_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_out_if: alarm event channel
// One beat carries one alarm transition with its evidence counters.
// ----------------------------------------------------------------------------
interface tah_out_if;
    logic                         valid;
    logic                         ready;
    logic [tah_pkg::LVL_W-1:0]    level;
    logic                         resolved;
    logic [tah_pkg::KB_W-1:0]     value_kb;
    logic [tah_pkg::KB_W-1:0]     max_seen_kb;
    logic [tah_pkg::RUN_W-1:0]    run_hits;
    logic [tah_pkg::TOT_W-1:0]    all_hits;
    logic [tah_pkg::WIN_W-1:0]    window_seconds;

    modport source (output valid, output level, output resolved, output value_kb,
                    output max_seen_kb, output run_hits, output all_hits,
                    output window_seconds, input ready);
    modport sink   (input valid, input level, input resolved, input value_kb,
                    input max_seen_kb, input run_hits, input all_hits,
                    input window_seconds, output ready);
endinterface

### sv/tah_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_cfg_if: register write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface tah_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tah_pkg::CFG_IDX_W-1:0]   index;
    logic [tah_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/tah_win.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_win: reported window length in seconds
// Registered interval_ms * warning_windows / 1000, refreshed every cycle,
// with a busy flag that covers the two-stage settle after reset or a write.
// ----------------------------------------------------------------------------
module tah_win (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_write,
    input  logic [tah_pkg::MS_W-1:0]        i_interval_ms,
    input  logic [tah_pkg::RUN_W-1:0]       i_warning_windows,
    output logic [tah_pkg::WIN_W-1:0]       o_window_seconds,
    output logic                            o_busy
);

    localparam int PROD_W = tah_pkg::MS_W + tah_pkg::RUN_W;
    localparam int Y_W    = PROD_W - tah_pkg::SEC_PRE_SHIFT;
    localparam int MUL_W  = Y_W + tah_pkg::SEC_RECIP_W;

    logic [PROD_W-1:0]          r_prod;
    logic [tah_pkg::WIN_W-1:0]  r_win;
    logic [1:0]                 r_hold;
    logic [1:0]                 n_hold;
    logic [MUL_W-1:0]           win_mul;

    // Stage one: the raw product in ms
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_interval_ms) * PROD_W'(i_warning_windows);
    end

    // Stage two: divide by 1000 through the reciprocal
    assign win_mul = MUL_W'(r_prod[PROD_W-1:tah_pkg::SEC_PRE_SHIFT])
                   * MUL_W'(tah_pkg::SEC_RECIP);

    always_ff @(posedge i_clk) begin
        r_win <= win_mul[tah_pkg::SEC_SHIFT +: tah_pkg::WIN_W];
    end

    // Count down the settle time after reset or a register write
    always_comb begin
        if (i_cfg_write) begin
            n_hold = 2'd2;
        end else if (r_hold != 2'd0) begin
            n_hold = r_hold - 2'd1;
        end else begin
            n_hold = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 2'd2;
        end else begin
            r_hold <= n_hold;
        end
    end

    assign o_window_seconds = r_win;
    assign o_busy           = (r_hold != 2'd0);

endmodule

### sv/threshold_alarm_with_hysteresis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_alarm_with_hysteresis: memory pressure alarm, three levels
// Counts consecutive samples per band and raises or clears the alarm.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one available-memory sample (kB) per beat; o_out carries
//   one alarm event (warning, critical or recovery) per beat; i_cfg writes
//   one register per beat and is always ready.
//   A sample lands in an input register, is evaluated there against the
//   alarm state and its event, if any, is loaded into the output register
//   that drives o_out.valid. The input and output registers form a
//   two-stage pipeline, so a new sample is taken every cycle while the
//   output is drained and no register write or divider settle holds it off.
//   If the receiver holds o_out.ready low, the output register keeps its
//   beat and the input register fills, then i_in.ready drops; no sample is
//   lost or evaluated twice.
//   After reset (i_rst_n low at a clock edge) the registers return to their
//   defaults, the alarm is normal, all counters are zero, and input is held
//   off while the window-seconds divider settles. The same hold follows
//   every register write.
// ----------------------------------------------------------------------------
module threshold_alarm_with_hysteresis (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tah_in_if.sink      i_in,
    tah_out_if.source   o_out,
    tah_cfg_if.sink     i_cfg
);

    // Configuration registers
    logic                               r_rule_enable;
    logic [tah_pkg::MB_W-1:0]           r_critical_mb;
    logic [tah_pkg::MB_W-1:0]           r_warning_mb;
    logic [tah_pkg::MB_W-1:0]           r_recovery_mb;
    logic [tah_pkg::RUN_W-1:0]          r_critical_windows;
    logic [tah_pkg::RUN_W-1:0]          r_warning_windows;
    logic [tah_pkg::RUN_W-1:0]          r_recovery_windows;
    logic [tah_pkg::MS_W-1:0]           r_interval_ms;

    // Input stage
    logic                               r_s1_valid;
    logic [tah_pkg::KB_W-1:0]           r_s1_kb;
    logic                               r_s1_sv;

    // Alarm state
    logic [tah_pkg::LVL_W-1:0]          r_level;
    logic [tah_pkg::RUN_W-1:0]          r_hit_run;
    logic [tah_pkg::RUN_W-1:0]          r_crit_run;
    logic [tah_pkg::RUN_W-1:0]          r_rec_run;
    logic [tah_pkg::TOT_W-1:0]          r_total;
    logic [tah_pkg::KB_W-1:0]           r_peak;
    logic [tah_pkg::LVL_W-1:0]          n_level;
    logic [tah_pkg::RUN_W-1:0]          n_hit_run;
    logic [tah_pkg::RUN_W-1:0]          n_crit_run;
    logic [tah_pkg::RUN_W-1:0]          n_rec_run;
    logic [tah_pkg::TOT_W-1:0]          n_total;
    logic [tah_pkg::KB_W-1:0]           n_peak;

    // Output stage
    logic                               r_out_valid;
    logic [tah_pkg::LVL_W-1:0]          r_out_level;
    logic                               r_out_resolved;
    logic [tah_pkg::KB_W-1:0]           r_out_kb;
    logic [tah_pkg::KB_W-1:0]           r_out_max;
    logic [tah_pkg::RUN_W-1:0]          r_out_run;
    logic [tah_pkg::TOT_W-1:0]          r_out_all;
    logic [tah_pkg::WIN_W-1:0]          r_out_win;

    // Evaluation
    logic                               cfg_write;
    logic                               win_busy;
    logic [tah_pkg::WIN_W-1:0]          win_sec;
    logic                               out_free;
    logic                               s1_adv;
    logic                               in_ready;
    logic                               act;
    logic                               in_crit;
    logic                               in_warn;
    logic                               in_rec;
    logic [tah_pkg::RUN_W-1:0]          hit_inc;
    logic [tah_pkg::RUN_W-1:0]          crit_inc;
    logic [tah_pkg::RUN_W-1:0]          rec_inc;
    logic                               emit;
    logic [tah_pkg::LVL_W-1:0]          ev_code;
    logic                               ev_resolved;

    // Register writes
    assign cfg_write   = i_cfg.valid;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_enable      <= 1'b1;
            r_critical_mb      <= tah_pkg::RST_CRITICAL_MB;
            r_warning_mb       <= tah_pkg::RST_WARNING_MB;
            r_recovery_mb      <= tah_pkg::RST_RECOVERY_MB;
            r_critical_windows <= tah_pkg::RST_WINDOWS;
            r_warning_windows  <= tah_pkg::RST_WINDOWS;
            r_recovery_windows <= tah_pkg::RST_WINDOWS;
            r_interval_ms      <= tah_pkg::RST_INTERVAL_MS;
        end else if (cfg_write) begin
            unique case (i_cfg.index)
                tah_pkg::CFG_RULE_ENABLE: begin
                    r_rule_enable <= i_cfg.data[0];
                end
                tah_pkg::CFG_CRITICAL_MB: begin
                    r_critical_mb <= i_cfg.data;
                end
                tah_pkg::CFG_WARNING_MB: begin
                    r_warning_mb <= i_cfg.data;
                end
                tah_pkg::CFG_RECOVERY_MB: begin
                    r_recovery_mb <= i_cfg.data;
                end
                tah_pkg::CFG_CRITICAL_WINDOWS: begin
                    r_critical_windows <= i_cfg.data[tah_pkg::RUN_W-1:0];
                end
                tah_pkg::CFG_WARNING_WINDOWS: begin
                    r_warning_windows <= i_cfg.data[tah_pkg::RUN_W-1:0];
                end
                tah_pkg::CFG_RECOVERY_WINDOWS: begin
                    r_recovery_windows <= i_cfg.data[tah_pkg::RUN_W-1:0];
                end
                tah_pkg::CFG_INTERVAL_MS: begin
                    r_interval_ms <= i_cfg.data[tah_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Window seconds, computed from the registers
    tah_win u_win (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_write       (cfg_write),
        .i_interval_ms     (r_interval_ms),
        .i_warning_windows (r_warning_windows),
        .o_window_seconds  (win_sec),
        .o_busy            (win_busy)
    );

    // Pipeline flow
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign in_ready   = (!r_s1_valid || out_free) && !win_busy && !cfg_write;
    assign i_in.ready = in_ready;

    // Capture the sample beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_kb <= i_in.available_kb;
            r_s1_sv <= i_in.sample_valid;
        end
    end

    // Band tests, thresholds scaled to kB
    assign act      = r_s1_sv && r_rule_enable;
    assign in_crit  = r_s1_kb <= {r_critical_mb, tah_pkg::KB_SHIFT'(0)};
    assign in_warn  = r_s1_kb <= {r_warning_mb, tah_pkg::KB_SHIFT'(0)};
    assign in_rec   = r_s1_kb >= {r_recovery_mb, tah_pkg::KB_SHIFT'(0)};
    assign hit_inc  = tah_pkg::run_inc(r_hit_run);
    assign crit_inc = tah_pkg::run_inc(r_crit_run);
    assign rec_inc  = tah_pkg::run_inc(r_rec_run);

    // Next alarm state and event decision
    always_comb begin
        n_level     = r_level;
        n_hit_run   = r_hit_run;
        n_crit_run  = r_crit_run;
        n_rec_run   = r_rec_run;
        n_total     = r_total;
        n_peak      = r_peak;
        emit        = 1'b0;
        ev_code     = tah_pkg::EV_WARNING;
        ev_resolved = 1'b0;
        if (act) begin
            if (r_s1_kb > r_peak) begin
                n_peak = r_s1_kb;
            end
            if (in_crit) begin
                n_hit_run  = hit_inc;
                n_crit_run = crit_inc;
                n_total    = tah_pkg::total_inc(r_total);
                n_rec_run  = '0;
                if (hit_inc >= r_critical_windows && crit_inc >= r_critical_windows &&
                    r_level != tah_pkg::LVL_CRITICAL) begin
                    n_level = tah_pkg::LVL_CRITICAL;
                    emit    = 1'b1;
                    ev_code = tah_pkg::EV_CRITICAL;
                end
            end else if (in_warn) begin
                n_hit_run  = hit_inc;
                n_total    = tah_pkg::total_inc(r_total);
                n_crit_run = '0;
                n_rec_run  = '0;
                if (hit_inc >= r_warning_windows && r_level == tah_pkg::LVL_NORMAL) begin
                    n_level = tah_pkg::LVL_WARNING;
                    emit    = 1'b1;
                    ev_code = tah_pkg::EV_WARNING;
                end
            end else if (in_rec && r_level != tah_pkg::LVL_NORMAL) begin
                n_rec_run = rec_inc;
                if (rec_inc >= r_recovery_windows) begin
                    n_level     = tah_pkg::LVL_NORMAL;
                    n_hit_run   = '0;
                    n_crit_run  = '0;
                    emit        = 1'b1;
                    ev_code     = tah_pkg::EV_RECOVERY;
                    ev_resolved = 1'b1;
                end
            end else begin
                n_hit_run  = '0;
                n_crit_run = '0;
                n_rec_run  = '0;
            end
        end
    end

    // Advance the alarm state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= tah_pkg::LVL_NORMAL;
            r_hit_run  <= '0;
            r_crit_run <= '0;
            r_rec_run  <= '0;
            r_total    <= '0;
            r_peak     <= '0;
        end else if (s1_adv) begin
            r_level    <= n_level;
            r_hit_run  <= n_hit_run;
            r_crit_run <= n_crit_run;
            r_rec_run  <= n_rec_run;
            r_total    <= n_total;
            r_peak     <= n_peak;
        end
    end

    // Load the event beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out_level    <= ev_code;
            r_out_resolved <= ev_resolved;
            r_out_kb       <= r_s1_kb;
            r_out_max      <= n_peak;
            r_out_run      <= n_hit_run;
            r_out_all      <= n_total;
            r_out_win      <= win_sec;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.level          = r_out_level;
    assign o_out.resolved       = r_out_resolved;
    assign o_out.value_kb       = r_out_kb;
    assign o_out.max_seen_kb    = r_out_max;
    assign o_out.run_hits       = r_out_run;
    assign o_out.all_hits       = r_out_all;
    assign o_out.window_seconds = r_out_win;

    // Checks
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_busy |-> !in_ready)
        else $error("sample accepted while window divider settles");

    a_event_moves_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && emit) |=> (r_level != $past(r_level)))
        else $error("event issued without a level change");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_total >= $past(r_total)))
        else $error("hit total went down");

    a_resolved_is_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_resolved) |-> (r_out_level == tah_pkg::EV_RECOVERY))
        else $error("resolved flag on a non-recovery event");

endmodule
